### rtl/nfc_rfd_pkg.sv
// ----------------------------------------------------------------------------
// NFC response frame deframer package
// Frame constants, status codes and phase encoding shared by the deframer.
// ----------------------------------------------------------------------------
package nfc_rfd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned StatusW = 3;

    localparam logic [ByteW-1:0] PREAMBLE   = 8'h00;
    localparam logic [ByteW-1:0] START_CODE1 = 8'h00;
    localparam logic [ByteW-1:0] START_CODE2 = 8'hFF;
    localparam logic [ByteW-1:0] FRAME_ID   = 8'hD5;
    localparam logic [ByteW-1:0] LIMIT_CAP  = 8'd254;
    localparam logic [ByteW-1:0] MAX_LEN_RESET = 8'd254;

    typedef logic [ByteW-1:0] byte_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_BAD_START = 3'd2,
        ST_LEN_SUM   = 3'd3,
        ST_BAD_ID    = 3'd4,
        ST_TOO_LONG  = 3'd5,
        ST_DATA_SUM  = 3'd6,
        ST_CUT_SHORT = 3'd7
    } status_t;

    typedef enum logic [9:0] {
        PH_IDLE = 10'b00_0000_0001,
        PH_PRE  = 10'b00_0000_0010,
        PH_SC1  = 10'b00_0000_0100,
        PH_SC2  = 10'b00_0000_1000,
        PH_LEN  = 10'b00_0001_0000,
        PH_LCS  = 10'b00_0010_0000,
        PH_TFI  = 10'b00_0100_0000,
        PH_DATA = 10'b00_1000_0000,
        PH_DCS  = 10'b01_0000_0000,
        PH_POST = 10'b10_0000_0000
    } phase_t;

endpackage

### rtl/nfc_response_frame_deframer.sv
// ----------------------------------------------------------------------------
// NFC response frame deframer
// Checks a controller response frame byte by byte and forwards its payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received word per handshake (rx_byte, frame_start),
//   taken when in_valid is high and in_stall is low. frame_start marks the
//   ready byte that opens a frame.
//   Output channel: at most one word per input word, held while out_stall is
//   high. A payload word carries out_byte and byte_index with last low; the
//   frame-ending word has last high, status and payload_length.
//   Config channel: max_data_len written on cfg_valid with cfg_ready (always
//   high); write only while the block is idle.
//   Path: output valid rises after input acceptance (input register, then
//   result register). Throughput: one word per cycle while out_stall is
//   low, set by the single registered pass from the input register to the
//   result register. A stalled receiver fills the result register; the
//   input register then holds and in_stall rises until the result is taken.
//   Reset: all handshake state clears, the parser waits for a frame start and
//   max_data_len returns to 254.
// ----------------------------------------------------------------------------
module nfc_response_frame_deframer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  nfc_rfd_pkg::byte_t     max_data_len,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  nfc_rfd_pkg::byte_t     rx_byte,
    input  logic                   frame_start,
    output logic                   out_valid,
    input  logic                   out_stall,
    output nfc_rfd_pkg::byte_t     out_byte,
    output nfc_rfd_pkg::byte_t     byte_index,
    output logic                   last,
    output logic [2:0]             status,
    output nfc_rfd_pkg::byte_t     payload_length
);
    import nfc_rfd_pkg::*;

    byte_t   max_len_reg;
    logic    in_valid_reg;
    byte_t   rx_byte_reg;
    logic    frame_start_reg;

    phase_t  phase_reg;
    phase_t  phase_next;
    byte_t   frame_len_reg;
    byte_t   frame_len_next;
    byte_t   count_reg;
    byte_t   count_next;
    byte_t   sum_reg;
    byte_t   sum_next;

    logic    out_valid_reg;
    byte_t   out_byte_reg;
    byte_t   out_byte_next;
    byte_t   index_reg;
    byte_t   index_next;
    logic    last_reg;
    logic    last_next;
    status_t status_reg;
    status_t status_next;
    byte_t   plen_reg;
    byte_t   plen_next;
    logic    res_valid;

    logic    out_ready;
    logic    step_fire;
    byte_t   data_len;
    byte_t   limit;
    byte_t   sum_add;
    byte_t   count_inc;

    assign cfg_ready = 1'b1;
    assign out_ready = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !out_ready;
    assign step_fire = in_valid_reg && out_ready;

    assign data_len  = frame_len_reg - 8'd1;
    assign limit     = (max_len_reg > LIMIT_CAP) ? LIMIT_CAP : max_len_reg;
    assign sum_add   = sum_reg + rx_byte_reg;
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        res_valid      = 1'b0;
        out_byte_next  = '0;
        index_next     = '0;
        last_next      = 1'b0;
        status_next    = ST_OK;
        plen_next      = '0;

        if (frame_start_reg)
        begin
            frame_len_next = '0;
            count_next     = '0;
            sum_next       = '0;
            if (phase_reg != PH_IDLE)
            begin
                res_valid   = 1'b1;
                last_next   = 1'b1;
                status_next = ST_CUT_SHORT;
            end
            if (!rx_byte_reg[0])
            begin
                phase_next = PH_IDLE;
                if (phase_reg == PH_IDLE)
                begin
                    res_valid   = 1'b1;
                    last_next   = 1'b1;
                    status_next = ST_NOT_READY;
                end
            end
            else
            begin
                phase_next = PH_PRE;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_PRE:
                begin
                    phase_next = PH_SC1;
                    if (rx_byte_reg != PREAMBLE)
                    begin
                        res_valid   = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_BAD_START;
                        phase_next  = PH_IDLE;
                    end
                end
                PH_SC1:
                begin
                    phase_next = PH_SC2;
                    if (rx_byte_reg != START_CODE1)
                    begin
                        res_valid   = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_BAD_START;
                        phase_next  = PH_IDLE;
                    end
                end
                PH_SC2:
                begin
                    phase_next = PH_LEN;
                    if (rx_byte_reg != START_CODE2)
                    begin
                        res_valid   = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_BAD_START;
                        phase_next  = PH_IDLE;
                    end
                end
                PH_LEN:
                begin
                    frame_len_next = rx_byte_reg;
                    phase_next     = PH_LCS;
                end
                PH_LCS:
                begin
                    phase_next = PH_TFI;
                    if ((frame_len_reg + rx_byte_reg) != 8'd0)
                    begin
                        res_valid   = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_LEN_SUM;
                        phase_next  = PH_IDLE;
                    end
                end
                PH_TFI:
                begin
                    if (rx_byte_reg != FRAME_ID)
                    begin
                        res_valid   = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_BAD_ID;
                        phase_next  = PH_IDLE;
                    end
                    else if (data_len > limit)
                    begin
                        res_valid   = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_TOO_LONG;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        sum_next   = FRAME_ID;
                        count_next = '0;
                        phase_next = (data_len == 8'd0) ? PH_DCS : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    res_valid     = 1'b1;
                    out_byte_next = rx_byte_reg;
                    index_next    = count_reg;
                    sum_next      = sum_add;
                    count_next    = count_inc;
                    if (count_inc >= data_len)
                    begin
                        phase_next = PH_DCS;
                    end
                end
                PH_DCS:
                begin
                    sum_next   = sum_add;
                    phase_next = PH_POST;
                    if (sum_add != 8'd0)
                    begin
                        res_valid   = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_DATA_SUM;
                        phase_next  = PH_IDLE;
                    end
                end
                PH_POST:
                begin
                    res_valid   = 1'b1;
                    last_next   = 1'b1;
                    status_next = ST_OK;
                    plen_next   = data_len;
                    phase_next  = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            frame_len_reg <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= max_data_len;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_fire)
            begin
                phase_reg     <= phase_next;
                frame_len_reg <= frame_len_next;
                count_reg     <= count_next;
                sum_reg       <= sum_next;
            end
            if (out_ready)
            begin
                out_valid_reg <= step_fire && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rx_byte_reg     <= rx_byte;
            frame_start_reg <= frame_start;
        end
        if (step_fire && res_valid)
        begin
            out_byte_reg <= out_byte_next;
            index_reg    <= index_next;
            last_reg     <= last_next;
            status_reg   <= status_next;
            plen_reg     <= plen_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_index     = index_reg;
    assign last           = last_reg;
    assign status         = status_reg;
    assign payload_length = plen_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result register can drain");

    a_payload_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (status == ST_OK && payload_length == 8'd0))
        else $error("payload word carries status or length");

    a_error_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last && status != ST_OK) |-> (payload_length == 8'd0
            && out_byte == 8'd0 && byte_index == 8'd0))
        else $error("error end carries nonzero fields");

    a_data_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (count_reg < data_len))
        else $error("payload count ran past frame length");

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid)) |-> $past(step_fire))
        else $error("result appeared without a processed word");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFC response frame deframer testbench
// Sends response frames one byte word at a time: clean frames, every error
// status, length limits at both extremes and random traffic with sender gaps
// and receiver stalls. A byte-level frame parser predicts each result word,
// and a checker compares every returned word field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import nfc_rfd_pkg::*;

    typedef struct packed {
        byte_t   data;
        byte_t   index;
        logic    last;
        status_t status;
        byte_t   plen;
    } deframed_word_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    byte_t   max_data_len = MAX_LEN_RESET;
    logic    in_valid = 1'b0;
    logic    in_stall;
    byte_t   rx_byte = '0;
    logic    frame_start = 1'b0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    byte_t   out_byte;
    byte_t   byte_index;
    logic    last;
    logic [2:0] status;
    byte_t   payload_length;

    deframed_word_t deframed_words[$];
    byte_t          frame_bytes[$];

    phase_t ph = PH_IDLE;
    byte_t  frame_len = '0;
    byte_t  byte_cnt = '0;
    byte_t  run_sum = '0;
    byte_t  len_limit = MAX_LEN_RESET;

    int  errors = 0;
    int  words_sent = 0;
    int  burst_left = 0;
    int  stall_left = 0;
    bit  stall_on = 1'b0;
    bit  tx_gaps = 1'b0;
    bit  rx_stalls = 1'b0;

    nfc_response_frame_deframer i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .max_data_len   (max_data_len),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_index     (byte_index),
        .last           (last),
        .status         (status),
        .payload_length (payload_length)
    );

    always #1 clk = ~clk;

    function automatic void end_frame(status_t st, byte_t plen);
        deframed_word_t w;
        w = '0;
        w.last = 1'b1;
        w.status = st;
        w.plen = plen;
        deframed_words.push_back(w);
        ph = PH_IDLE;
    endfunction

    function automatic void parse_rx_word(byte_t b, logic fs);
        deframed_word_t w;
        byte_t data_len;
        byte_t lim;
        data_len = frame_len - 8'd1;
        lim = (len_limit > LIMIT_CAP) ? LIMIT_CAP : len_limit;
        w = '0;
        if (fs)
        begin
            if (ph != PH_IDLE)
                end_frame(ST_CUT_SHORT, 8'd0);
            else if (!b[0])
                end_frame(ST_NOT_READY, 8'd0);
            frame_len = '0;
            byte_cnt = '0;
            run_sum = '0;
            ph = b[0] ? PH_PRE : PH_IDLE;
            return;
        end
        case (ph)
            PH_PRE:
                if (b != PREAMBLE) end_frame(ST_BAD_START, 8'd0);
                else ph = PH_SC1;
            PH_SC1:
                if (b != START_CODE1) end_frame(ST_BAD_START, 8'd0);
                else ph = PH_SC2;
            PH_SC2:
                if (b != START_CODE2) end_frame(ST_BAD_START, 8'd0);
                else ph = PH_LEN;
            PH_LEN:
            begin
                frame_len = b;
                ph = PH_LCS;
            end
            PH_LCS:
                if (byte_t'(frame_len + b) != 8'd0) end_frame(ST_LEN_SUM, 8'd0);
                else ph = PH_TFI;
            PH_TFI:
                if (b != FRAME_ID)
                    end_frame(ST_BAD_ID, 8'd0);
                else if (data_len > lim)
                    end_frame(ST_TOO_LONG, 8'd0);
                else
                begin
                    run_sum = FRAME_ID;
                    byte_cnt = '0;
                    ph = (data_len == 8'd0) ? PH_DCS : PH_DATA;
                end
            PH_DATA:
            begin
                w.data = b;
                w.index = byte_cnt;
                deframed_words.push_back(w);
                run_sum = run_sum + b;
                byte_cnt = byte_cnt + 8'd1;
                if (byte_cnt >= data_len)
                    ph = PH_DCS;
            end
            PH_DCS:
            begin
                run_sum = run_sum + b;
                if (run_sum != 8'd0) end_frame(ST_DATA_SUM, 8'd0);
                else ph = PH_POST;
            end
            PH_POST:
                end_frame(ST_OK, data_len);
            default:
                ph = PH_IDLE;
        endcase
    endfunction

    function automatic void build_frame(int n);
        byte_t len;
        byte_t sum;
        byte_t v;
        frame_bytes.delete();
        len = byte_t'(n + 1);
        sum = FRAME_ID;
        frame_bytes.push_back(byte_t'($urandom) | 8'h01);
        frame_bytes.push_back(PREAMBLE);
        frame_bytes.push_back(START_CODE1);
        frame_bytes.push_back(START_CODE2);
        frame_bytes.push_back(len);
        frame_bytes.push_back(8'd0 - len);
        frame_bytes.push_back(FRAME_ID);
        for (int i = 0; i < n; i++)
        begin
            v = byte_t'($urandom);
            sum = sum + v;
            frame_bytes.push_back(v);
        end
        frame_bytes.push_back(8'd0 - sum);
        frame_bytes.push_back(byte_t'($urandom));
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t ns: %s is %0d, expected %0d", $time, field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        deframed_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (deframed_words.size() == 0)
                report_mismatch("unexpected word, last", int'(last), 0);
            else
            begin
                w = deframed_words.pop_front();
                if (out_byte !== w.data) report_mismatch("out_byte", out_byte, w.data);
                if (byte_index !== w.index) report_mismatch("byte_index", byte_index, w.index);
                if (last !== w.last) report_mismatch("last", last, w.last);
                if (status !== w.status) report_mismatch("status", status, w.status);
                if (payload_length !== w.plen)
                    report_mismatch("payload_length", payload_length, w.plen);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_on = !stall_on;
            if (stall_on)
                stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(1, 4);
            else
                stall_left = $urandom_range(1, 10);
        end
        stall_left--;
        out_stall <= stall_on && rx_stalls;
    end

    task automatic send_word(byte_t b, logic fs);
        int  gap;
        bit  stalled;
        if (burst_left == 0)
        begin
            gap = tx_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_start <= fs;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        parse_rx_word(b, fs);
        words_sent++;
    endtask

    task automatic send_frame_bytes(int count);
        int n;
        n = (count < 0 || count > frame_bytes.size()) ? frame_bytes.size() : count;
        for (int i = 0; i < n; i++)
            send_word(frame_bytes[i], i == 0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (deframed_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_len_limit(byte_t v);
        bit ready;
        wait_idle();
        cfg_valid <= 1'b1;
        max_data_len <= v;
        do
        begin
            @(negedge clk);
            ready = cfg_ready;
            @(posedge clk);
        end
        while (!ready);
        cfg_valid <= 1'b0;
        len_limit = v;
    endtask

    task automatic test_clean_frames();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        build_frame(0);
        send_frame_bytes(-1);
        build_frame(1);
        send_frame_bytes(-1);
        build_frame(3);
        send_frame_bytes(-1);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        build_frame(5);
        send_frame_bytes(-1);
    endtask

    task automatic test_frame_errors();
        send_word(8'h3C, 1'b1);
        send_word(8'hA5, 1'b0);
        build_frame(2);
        frame_bytes[1] = 8'h01;
        send_frame_bytes(2);
        build_frame(2);
        frame_bytes[2] = 8'h80;
        send_frame_bytes(3);
        build_frame(2);
        frame_bytes[3] = 8'hFE;
        send_frame_bytes(4);
        build_frame(2);
        frame_bytes[5] ^= 8'h10;
        send_frame_bytes(6);
        build_frame(2);
        frame_bytes[6] = 8'hD4;
        send_frame_bytes(7);
        build_frame(2);
        frame_bytes[4] = 8'h00;
        frame_bytes[5] = 8'h00;
        send_frame_bytes(7);
        frame_bytes[6] = 8'h2A;
        send_frame_bytes(7);
        build_frame(2);
        frame_bytes[9] ^= 8'h01;
        send_frame_bytes(10);
        build_frame(4);
        send_frame_bytes(9);
        build_frame(0);
        send_frame_bytes(-1);
        build_frame(3);
        send_frame_bytes(5);
        send_word(8'hFE, 1'b1);
        send_word(8'h00, 1'b0);
    endtask

    task automatic test_length_limit();
        set_len_limit(8'd0);
        build_frame(0);
        send_frame_bytes(-1);
        build_frame(1);
        send_frame_bytes(7);
        set_len_limit(8'd255);
        build_frame(254);
        send_frame_bytes(-1);
        build_frame(2);
        frame_bytes[4] = 8'h00;
        frame_bytes[5] = 8'h00;
        send_frame_bytes(7);
        set_len_limit(8'd1);
        build_frame(1);
        send_frame_bytes(-1);
        build_frame(2);
        send_frame_bytes(7);
    endtask

    task automatic test_random_traffic();
        int    start;
        int    n;
        int    lim;
        int    pos;
        byte_t v;
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: v = MAX_LEN_RESET;
                2: v = 8'd0;
                3: v = 8'd255;
                4: v = 8'd1;
                6: v = MAX_LEN_RESET;
                default: v = byte_t'($urandom_range(2, 253));
            endcase
            set_len_limit(v);
            tx_gaps = (p % 3 != 2);
            rx_stalls = (p % 4 != 1);
            lim = (len_limit > LIMIT_CAP) ? LIMIT_CAP : len_limit;
            start = words_sent;
            while (words_sent - start < 170)
            begin
                if ($urandom_range(0, 49) == 0)
                    n = $urandom_range(200, 254);
                else if ($urandom_range(0, 9) < 8)
                    n = $urandom_range(0, (lim < 12) ? lim : 12);
                else
                    n = $urandom_range(0, 20);
                build_frame(n);
                case ($urandom_range(0, 9))
                    6:
                    begin
                        pos = $urandom_range(0, frame_bytes.size() - 1);
                        frame_bytes[pos] ^= byte_t'($urandom_range(1, 255));
                        send_frame_bytes(-1);
                    end
                    7:
                        send_frame_bytes($urandom_range(1, frame_bytes.size() - 1));
                    8:
                    begin
                        frame_bytes[0][0] = 1'b0;
                        send_frame_bytes(-1);
                    end
                    9:
                    begin
                        frame_bytes[4] = ($urandom_range(0, 1) == 0) ? 8'd0
                                                                    : byte_t'($urandom);
                        frame_bytes[5] = 8'd0 - frame_bytes[4];
                        send_frame_bytes(-1);
                    end
                    default:
                        send_frame_bytes(-1);
                endcase
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(byte_t'($urandom), 1'b0);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_clean_frames();
        test_frame_errors();
        test_length_limit();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0 && deframed_words.size() == 0)
            $display("nfc_response_frame_deframer: match");
        else
            $display("nfc_response_frame_deframer: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("nfc_response_frame_deframer: mismatch");
        $finish;
    end

endmodule
